@@ rtl/i2ew_pkg.sv @@
// Shared types, word codes and the microcode program for the integer-to-words block.
// No dependencies; the sequencer and the decimal converter import it.
`timescale 1ns / 1ps

package i2ew_pkg;

    localparam int BCD_DIGITS = 12;
    localparam int BCD_BITS   = BCD_DIGITS * 4;
    localparam int STEP_W     = 5;
    localparam int GROUPS     = 4;

    localparam logic [4:0] CODE_ZERO      = 5'd0;
    localparam logic [4:0] CODE_TEEN_BASE = 5'd10;
    localparam logic [4:0] CODE_TENS_BASE = 5'd18;
    localparam logic [4:0] CODE_HUNDRED   = 5'd28;
    localparam logic [4:0] CODE_THOUSAND  = 5'd29;
    localparam logic [4:0] CODE_MILLION   = 5'd30;
    localparam logic [4:0] CODE_BILLION   = 5'd31;

    typedef enum logic [2:0] {
        OP_SHIFT,
        OP_ZCHK,
        OP_GCHK,
        OP_EMIT,
        OP_FLUSH
    } op_t;

    typedef enum logic [2:0] {
        K_HDIGIT,
        K_HUNDRED,
        K_TENS,
        K_UNITS,
        K_SCALE
    } kind_t;

    typedef struct packed {
        op_t               op;
        logic [1:0]        grp;
        kind_t             kind;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic load;
        logic shift;
    } bcd_ctl_t;

    localparam logic [STEP_W-1:0] STEP_FLUSH = 5'd25;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucode_t w;
        w = '{op: OP_FLUSH, grp: 2'd0, kind: K_HDIGIT, target: STEP_FLUSH};
        case (addr)
            5'd0:  w = '{op: OP_SHIFT, grp: 2'd0, kind: K_HDIGIT,  target: 5'd0};
            5'd1:  w = '{op: OP_ZCHK,  grp: 2'd0, kind: K_HDIGIT,  target: STEP_FLUSH};
            5'd2:  w = '{op: OP_GCHK,  grp: 2'd0, kind: K_HDIGIT,  target: 5'd8};
            5'd3:  w = '{op: OP_EMIT,  grp: 2'd0, kind: K_HDIGIT,  target: 5'd0};
            5'd4:  w = '{op: OP_EMIT,  grp: 2'd0, kind: K_HUNDRED, target: 5'd0};
            5'd5:  w = '{op: OP_EMIT,  grp: 2'd0, kind: K_TENS,    target: 5'd0};
            5'd6:  w = '{op: OP_EMIT,  grp: 2'd0, kind: K_UNITS,   target: 5'd0};
            5'd7:  w = '{op: OP_EMIT,  grp: 2'd0, kind: K_SCALE,   target: 5'd0};
            5'd8:  w = '{op: OP_GCHK,  grp: 2'd1, kind: K_HDIGIT,  target: 5'd14};
            5'd9:  w = '{op: OP_EMIT,  grp: 2'd1, kind: K_HDIGIT,  target: 5'd0};
            5'd10: w = '{op: OP_EMIT,  grp: 2'd1, kind: K_HUNDRED, target: 5'd0};
            5'd11: w = '{op: OP_EMIT,  grp: 2'd1, kind: K_TENS,    target: 5'd0};
            5'd12: w = '{op: OP_EMIT,  grp: 2'd1, kind: K_UNITS,   target: 5'd0};
            5'd13: w = '{op: OP_EMIT,  grp: 2'd1, kind: K_SCALE,   target: 5'd0};
            5'd14: w = '{op: OP_GCHK,  grp: 2'd2, kind: K_HDIGIT,  target: 5'd20};
            5'd15: w = '{op: OP_EMIT,  grp: 2'd2, kind: K_HDIGIT,  target: 5'd0};
            5'd16: w = '{op: OP_EMIT,  grp: 2'd2, kind: K_HUNDRED, target: 5'd0};
            5'd17: w = '{op: OP_EMIT,  grp: 2'd2, kind: K_TENS,    target: 5'd0};
            5'd18: w = '{op: OP_EMIT,  grp: 2'd2, kind: K_UNITS,   target: 5'd0};
            5'd19: w = '{op: OP_EMIT,  grp: 2'd2, kind: K_SCALE,   target: 5'd0};
            5'd20: w = '{op: OP_GCHK,  grp: 2'd3, kind: K_HDIGIT,  target: STEP_FLUSH};
            5'd21: w = '{op: OP_EMIT,  grp: 2'd3, kind: K_HDIGIT,  target: 5'd0};
            5'd22: w = '{op: OP_EMIT,  grp: 2'd3, kind: K_HUNDRED, target: 5'd0};
            5'd23: w = '{op: OP_EMIT,  grp: 2'd3, kind: K_TENS,    target: 5'd0};
            5'd24: w = '{op: OP_EMIT,  grp: 2'd3, kind: K_UNITS,   target: 5'd0};
            default: w = '{op: OP_FLUSH, grp: 2'd0, kind: K_HDIGIT, target: STEP_FLUSH};
        endcase
        return w;
    endfunction

    function automatic logic [4:0] scale_code(input logic [1:0] grp);
        logic [4:0] c;
        case (grp)
            2'd0:    c = CODE_BILLION;
            2'd1:    c = CODE_MILLION;
            2'd2:    c = CODE_THOUSAND;
            default: c = CODE_ZERO;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/i2ew_bcd.sv @@
// Bit-serial binary-to-decimal converter (shift and add-3), one input bit per shift.
// Depends on i2ew_pkg for the digit count and control struct.
`timescale 1ns / 1ps

module i2ew_bcd
    import i2ew_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bcd_ctl_t              ctl,
    input  logic [VALUE_BITS-1:0] value,
    output logic [BCD_BITS-1:0]   digits
);

    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [BCD_BITS-1:0]   bcd_next;
    logic [BCD_BITS-1:0]   adj;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctl.load)
        begin
            bin_next = value;
            bcd_next = '0;
        end
        else if (ctl.shift)
        begin
            bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next = {adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg <= '0;
            bcd_reg <= '0;
        end
        else
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign digits = bcd_reg;

endmodule

@@ rtl/integer_to_english_words.sv @@
// Top level: spells a non-negative integer as a stream of English word codes.
// Depends on i2ew_pkg (microcode, codes) and i2ew_bcd (decimal conversion).
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------------------
//  input    | value                          | taken when start & !busy
//  result   | word_code, last_word           | one cycle, marked by word_strobe
//
// Busy stays high while the bit-serial decimal converter shifts in all VALUE_BITS input bits,
// then for 2 to 25 program steps: an all-zero group costs one check step, a nonzero group
// its check plus every word step, emitting or not. A new item is taken only after busy
// drops. Each word leaves the cycle after the next emitting step, the final one the
// cycle after the flush step, with last_word set.
// Reset clears busy and the strobe. The receiver cannot stall; start is ignored while busy.
`timescale 1ns / 1ps

module integer_to_english_words
    import i2ew_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  busy,
    output logic                  word_strobe,
    output logic [4:0]            word_code,
    output logic                  last_word
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic                busy_reg,     busy_next;
    logic [STEP_W-1:0]   step_reg,     step_next;
    logic [CNT_W-1:0]    cnt_reg,      cnt_next;
    logic                pend_reg,     pend_next;
    logic [4:0]          pend_code_reg, pend_code_next;
    logic                strobe_reg,   strobe_next;
    logic [4:0]          code_reg,     code_next;
    logic                last_reg,     last_next;

    bcd_ctl_t            bcd_ctl;
    logic [BCD_BITS-1:0] digits;
    ucode_t              uw;
    logic [3:0]          dig_h;
    logic [3:0]          dig_t;
    logic [3:0]          dig_u;
    logic                emit_en;
    logic [4:0]          emit_code;

    i2ew_bcd #(
        .VALUE_BITS (VALUE_BITS)
    ) u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (bcd_ctl),
        .value  (value),
        .digits (digits)
    );

    assign uw = ucode_rom(step_reg);

    always_comb
    begin
        case (uw.grp)
            2'd0:
            begin
                dig_h = digits[44 +: 4];
                dig_t = digits[40 +: 4];
                dig_u = digits[36 +: 4];
            end
            2'd1:
            begin
                dig_h = digits[32 +: 4];
                dig_t = digits[28 +: 4];
                dig_u = digits[24 +: 4];
            end
            2'd2:
            begin
                dig_h = digits[20 +: 4];
                dig_t = digits[16 +: 4];
                dig_u = digits[12 +: 4];
            end
            default:
            begin
                dig_h = digits[8 +: 4];
                dig_t = digits[4 +: 4];
                dig_u = digits[0 +: 4];
            end
        endcase
    end

    // word selection for one emit step
    always_comb
    begin
        emit_en   = 1'b0;
        emit_code = CODE_ZERO;
        case (uw.kind)
            K_HDIGIT:
            begin
                emit_en   = (dig_h != 4'd0);
                emit_code = {1'b0, dig_h};
            end
            K_HUNDRED:
            begin
                emit_en   = (dig_h != 4'd0);
                emit_code = CODE_HUNDRED;
            end
            K_TENS:
            begin
                if (dig_t == 4'd1)
                begin
                    emit_en   = 1'b1;
                    emit_code = CODE_TEEN_BASE + {1'b0, dig_u};
                end
                else
                begin
                    emit_en   = (dig_t >= 4'd2);
                    emit_code = CODE_TENS_BASE + {1'b0, dig_t};
                end
            end
            K_UNITS:
            begin
                emit_en   = (dig_t != 4'd1) && (dig_u != 4'd0);
                emit_code = {1'b0, dig_u};
            end
            K_SCALE:
            begin
                emit_en   = 1'b1;
                emit_code = scale_code(uw.grp);
            end
            default:
            begin
                emit_en   = 1'b0;
                emit_code = CODE_ZERO;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_code_next = pend_code_reg;
        strobe_next    = 1'b0;
        code_next      = code_reg;
        last_next      = last_reg;
        bcd_ctl        = '{load: 1'b0, shift: 1'b0};

        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next    = 1'b1;
                step_next    = '0;
                cnt_next     = CNT_W'(VALUE_BITS);
                pend_next    = 1'b0;
                bcd_ctl.load = 1'b1;
            end
        end
        else
        begin
            case (uw.op)
                OP_SHIFT:
                begin
                    bcd_ctl.shift = 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                OP_ZCHK:
                begin
                    if (digits == '0)
                    begin
                        pend_next      = 1'b1;
                        pend_code_next = CODE_ZERO;
                        step_next      = uw.target;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                OP_GCHK:
                begin
                    if (dig_h == 4'd0 && dig_t == 4'd0 && dig_u == 4'd0)
                    begin
                        step_next = uw.target;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                OP_EMIT:
                begin
                    // hold one word back so the final one can be flagged
                    if (emit_en)
                    begin
                        strobe_next    = pend_reg;
                        code_next      = pend_code_reg;
                        last_next      = 1'b0;
                        pend_next      = 1'b1;
                        pend_code_next = emit_code;
                    end
                    step_next = step_reg + 1'b1;
                end
                OP_FLUSH:
                begin
                    strobe_next = pend_reg;
                    code_next   = pend_code_reg;
                    last_next   = 1'b1;
                    pend_next   = 1'b0;
                    busy_next   = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_code_reg <= pend_code_next;
        code_reg      <= code_next;
        last_reg      <= last_next;
    end

    assign busy        = busy_reg;
    assign word_strobe = strobe_reg;
    assign word_code   = code_reg;
    assign last_word   = last_reg;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for integer_to_english_words: drives numbers, predicts word codes.
// Depends on i2ew_pkg (word codes) and the integer_to_english_words RTL.
`timescale 1ns / 1ps

module testbench
    import i2ew_pkg::*;
;

    localparam int          VALUE_BITS = 31;
    localparam int unsigned VALUE_MAX  = 32'h7fff_ffff;
    localparam int          IDLE_LIMIT = 500;
    localparam int          DRAIN      = 64;

    typedef struct packed {
        logic [VALUE_BITS-1:0] src;
        logic [4:0]            code;
        logic                  last;
    } word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic [VALUE_BITS-1:0] value;
    logic                  busy;
    logic                  word_strobe;
    logic [4:0]            word_code;
    logic                  last_word;

    word_t expected_words[$];
    word_t next_word;
    int    error_count;
    int    idle_cycles;
    int    gap_max;

    integer_to_english_words #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .value(value),
        .busy(busy),
        .word_strobe(word_strobe),
        .word_code(word_code),
        .last_word(last_word)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void predict_words(input logic [VALUE_BITS-1:0] v);
        int unsigned num;
        int unsigned divisor;
        int unsigned g;
        int unsigned h;
        int unsigned r;
        int unsigned t;
        int unsigned u;
        logic [4:0]  codes[$];
        word_t       w;
        num = v;
        divisor = 1000000000;
        if (num == 0)
            codes.push_back(CODE_ZERO);
        for (int k = 0; k < 4; k++)
        begin
            g = (num / divisor) % 1000;
            if (g != 0)
            begin
                h = g / 100;
                r = g % 100;
                t = r / 10;
                u = r % 10;
                if (h != 0)
                begin
                    codes.push_back(5'(h));
                    codes.push_back(CODE_HUNDRED);
                end
                if (t == 1)
                    codes.push_back(5'(r));
                else
                begin
                    if (t >= 2)
                        codes.push_back(CODE_TENS_BASE + 5'(t));
                    if (u != 0)
                        codes.push_back(5'(u));
                end
                case (k)
                    0:       codes.push_back(CODE_BILLION);
                    1:       codes.push_back(CODE_MILLION);
                    2:       codes.push_back(CODE_THOUSAND);
                    default: ;
                endcase
            end
            divisor = divisor / 1000;
        end
        foreach (codes[i])
        begin
            w.src  = v;
            w.code = codes[i];
            w.last = (i == codes.size() - 1);
            expected_words.push_back(w);
        end
    endfunction

    // Hold start high until the block takes the item; drop it only across a gap.
    task automatic spell_number(input logic [VALUE_BITS-1:0] v);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        predict_words(v);
    endtask

    function automatic int unsigned random_group();
        int unsigned g;
        case ($urandom_range(0, 5))
            0:       g = 0;
            1:       g = $urandom_range(0, 9) * 100 + $urandom_range(10, 19);
            2:       g = $urandom_range(1, 9) * 100;
            3:       g = $urandom_range(0, 99);
            default: g = $urandom_range(0, 999);
        endcase
        return g;
    endfunction

    task automatic test_directed();
        int unsigned picks[$];
        picks = '{0, 1, 9, 10, 11, 15, 19, 20, 21, 99, 100, 101, 110, 119, 999,
                  1000, 1001, 100000, 1000000, 1000001, 7000000, 1000000000,
                  2000010005, 1234567890, VALUE_MAX};
        gap_max = 4;
        foreach (picks[i])
            spell_number(picks[i][VALUE_BITS-1:0]);
    endtask

    task automatic test_full_range();
        int unsigned v;
        for (int i = 0; i < 100; i++)
        begin
            gap_max = ((i / 20) % 2 == 0) ? 4 : 0;
            case ($urandom_range(0, 3))
                0:       v = VALUE_MAX - $urandom_range(0, 2000);
                default: v = $urandom() & VALUE_MAX;
            endcase
            spell_number(v[VALUE_BITS-1:0]);
        end
    endtask

    task automatic test_group_patterns();
        longint unsigned total;
        for (int i = 0; i < 230; i++)
        begin
            gap_max = ((i / 25) % 3 == 1) ? 0 : 4;
            total = longint'($urandom_range(0, 2)) * 1000000000 +
                    longint'(random_group()) * 1000000 +
                    longint'(random_group()) * 1000 +
                    longint'(random_group());
            if (total > VALUE_MAX)
                total = total - 1000000000;
            spell_number(total[VALUE_BITS-1:0]);
        end
    endtask

    task automatic test_small_values();
        int unsigned v;
        for (int i = 0; i < 80; i++)
        begin
            gap_max = (i < 40) ? 0 : 4;
            v = (i % 2 == 0) ? $urandom_range(0, 999) : random_group();
            spell_number(v[VALUE_BITS-1:0]);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && word_strobe)
        begin
            if (expected_words.size() == 0)
                report_mismatch($sformatf("unexpected word code %0d last %0b",
                                          word_code, last_word));
            else
            begin
                next_word = expected_words.pop_front();
                if (word_code !== next_word.code)
                    report_mismatch($sformatf("value %0d: word code %0d, want %0d",
                                              next_word.src, word_code, next_word.code));
                if (last_word !== next_word.last)
                    report_mismatch($sformatf("value %0d: last_word %0b, want %0b",
                                              next_word.src, last_word, next_word.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || word_strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        value       = '0;
        error_count = 0;
        idle_cycles = 0;
        gap_max     = 4;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_range();
        test_group_patterns();
        test_small_values();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
